// ===== hw/rtl/nrte_pkg.sv =====
// Shared types, character codes and helpers for the RMC time extractor.
`default_nettype none

package nrte_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NDigits = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 7;
  localparam int unsigned SecW    = 7;
  localparam int unsigned OfsW    = 5;
  localparam int unsigned OutDataW = 24;  // hour, minute, second packed, zero filled

  localparam logic [CharW-1:0] ChComma = 8'h2C;  // ','
  localparam logic [CharW-1:0] ChA     = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChStar  = 8'h2A;  // '*'
  localparam logic [CharW-1:0] ChR     = 8'h52;  // 'R'
  localparam logic [CharW-1:0] Ch0     = 8'h30;  // '0'
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoF   = 8'h66;

  localparam logic [7:0] HoursPerDay = 8'd24;

  // Time field occupies positions 7..12.
  localparam logic [CharW-1:0] TimeFirstPos = 8'd7;
  localparam logic [CharW-1:0] TimeLastPos  = 8'd12;
  localparam logic [CharW-1:0] TypePos      = 8'd3;

  // Sentence verdict handed from the parser to the output stage.
  typedef struct packed {
    logic                           ok;
    logic [NDigits-1:0][DigitW-1:0] digits;  // digit 0 = position 7
  } verdict_t;

  // Hex digit decode: valid flag plus 4-bit value.
  typedef struct packed {
    logic              valid;
    logic [DigitW-1:0] value;
  } hex_dig_t;

  function automatic hex_dig_t hex_digit(input logic [CharW-1:0] c);
    hex_dig_t r;
    logic [CharW-1:0] t;
    r = '0;
    t = '0;
    if (c >= Ch0 && c <= Ch9) begin
      t       = c - Ch0;
      r.valid = 1'b1;
      r.value = t[DigitW-1:0];
    end else if (c >= ChUpA && c <= ChUpF) begin
      t       = c - ChUpA + 8'd10;
      r.valid = 1'b1;
      r.value = t[DigitW-1:0];
    end else if (c >= ChLoA && c <= ChLoF) begin
      t       = c - ChLoA + 8'd10;
      r.valid = 1'b1;
      r.value = t[DigitW-1:0];
    end
    return r;
  endfunction

  // Two decimal digits to a binary value (max 165 for nibble inputs).
  function automatic logic [7:0] two_digits(input logic [DigitW-1:0] tens,
                                            input logic [DigitW-1:0] ones);
    return ({4'd0, tens} << 3) + ({4'd0, tens} << 1) + {4'd0, ones};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nrte_sentence.sv =====
// Per-sentence running state: type, status, checksum, hex field, time digits.
`default_nettype none

module nrte_sentence #(
  parameter int unsigned MAX_LEN = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,  // consume one character
  input  wire logic [nrte_pkg::CharW-1:0]   char_i,
  input  wire logic                         last_i,
  output nrte_pkg::verdict_t                verdict_o  // valid with step_i && last_i
);

  localparam logic [nrte_pkg::CharW-1:0] MaxLen = nrte_pkg::CharW'(MAX_LEN);

  logic [nrte_pkg::CharW-1:0] pos_q, pos_d;
  logic [1:0]                 comma_q, comma_d;
  logic                       type_ok_q, type_ok_d;
  logic                       status_ok_q, status_ok_d;
  logic                       star_q, star_d;
  logic [nrte_pkg::CharW-1:0] xor_q, xor_d;
  logic [7:0]                 hex_q, hex_d;
  logic                       hex_ovf_q, hex_ovf_d;
  logic                       hex_stop_q, hex_stop_d;
  logic                       too_long_q, too_long_d;
  logic [nrte_pkg::NDigits-1:0][nrte_pkg::DigitW-1:0] dig_q, dig_d;

  nrte_pkg::hex_dig_t         hd;
  logic [11:0]                hex_acc;
  logic [nrte_pkg::CharW-1:0] dig_ofs;
  logic [2:0]                 dig_idx;
  logic [nrte_pkg::CharW-1:0] dec_val;

  always_comb begin
    pos_d       = pos_q;
    comma_d     = comma_q;
    type_ok_d   = type_ok_q;
    status_ok_d = status_ok_q;
    star_d      = star_q;
    xor_d       = xor_q;
    hex_d       = hex_q;
    hex_ovf_d   = hex_ovf_q;
    hex_stop_d  = hex_stop_q;
    too_long_d  = too_long_q;
    dig_d       = dig_q;

    hd      = nrte_pkg::hex_digit(char_i);
    hex_acc = {hex_q, 4'd0} + {8'd0, hd.value};
    dig_ofs = pos_q - nrte_pkg::TimeFirstPos;
    dig_idx = dig_ofs[2:0];
    dec_val = char_i - nrte_pkg::Ch0;

    if (pos_q >= MaxLen) too_long_d = 1'b1;
    if (pos_q == nrte_pkg::TypePos) type_ok_d = (char_i == nrte_pkg::ChR);

    if (comma_q == 2'd2) begin
      status_ok_d = (char_i == nrte_pkg::ChA);
      comma_d     = 2'd3;
    end else if (comma_q < 2'd2 && char_i == nrte_pkg::ChComma) begin
      comma_d = comma_q + 2'd1;
    end

    // Position 1 always feeds the checksum, position 0 never does.
    if (pos_q == 8'd1) begin
      xor_d = xor_q ^ char_i;
    end else if (pos_q >= 8'd2) begin
      if (!star_q) begin
        if (char_i == nrte_pkg::ChStar) star_d = 1'b1;
        else xor_d = xor_q ^ char_i;
      end else if (!hex_stop_q) begin
        if (!hd.valid) hex_stop_d = 1'b1;
        else if (hex_acc > 12'd255) hex_ovf_d = 1'b1;
        else hex_d = hex_acc[7:0];
      end
    end

    if (pos_q >= nrte_pkg::TimeFirstPos && pos_q <= nrte_pkg::TimeLastPos) begin
      if (char_i >= nrte_pkg::Ch0 && char_i <= nrte_pkg::Ch9)
        dig_d[dig_idx] = dec_val[nrte_pkg::DigitW-1:0];
      else
        dig_d[dig_idx] = '0;
    end

    if (pos_q != 8'hFF) pos_d = pos_q + 8'd1;
  end

  always_comb begin
    verdict_o.ok     = type_ok_d && status_ok_d && star_d && !hex_ovf_d && !too_long_d
                       && (hex_d == xor_d);
    verdict_o.digits = dig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      comma_q     <= '0;
      type_ok_q   <= 1'b0;
      status_ok_q <= 1'b0;
      star_q      <= 1'b0;
      xor_q       <= '0;
      hex_q       <= '0;
      hex_ovf_q   <= 1'b0;
      hex_stop_q  <= 1'b0;
      too_long_q  <= 1'b0;
      dig_q       <= '0;
    end else if (step_i) begin
      if (last_i) begin
        // sentence done: clear everything for the next one
        pos_q       <= '0;
        comma_q     <= '0;
        type_ok_q   <= 1'b0;
        status_ok_q <= 1'b0;
        star_q      <= 1'b0;
        xor_q       <= '0;
        hex_q       <= '0;
        hex_ovf_q   <= 1'b0;
        hex_stop_q  <= 1'b0;
        too_long_q  <= 1'b0;
        dig_q       <= '0;
      end else begin
        pos_q       <= pos_d;
        comma_q     <= comma_d;
        type_ok_q   <= type_ok_d;
        status_ok_q <= status_ok_d;
        star_q      <= star_d;
        xor_q       <= xor_d;
        hex_q       <= hex_d;
        hex_ovf_q   <= hex_ovf_d;
        hex_stop_q  <= hex_stop_d;
        too_long_q  <= too_long_d;
        dig_q       <= dig_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_rmc_time_extract_top.sv =====
// Top level of the NMEA RMC sentence checker and time extractor.
`default_nettype none

// Takes an RMC-style sentence one character per input word (tlast on the final
// character) and emits one output word per sentence on its final character:
// tuser[0] says whether the sentence passed the type ('R' at position 3),
// status ('A' after the second comma) and '*' hex checksum checks and was no
// longer than MAX_LEN characters; tdata carries the held local time, updated
// only by accepted sentences from the hhmmss digits at positions 7..12 plus the
// zone offset, wrapped once at 24. Throughput is one character per clock while the
// input is not stalled: a character is held in the input register, then a single
// combinational pass updates the running sentence state and, on tlast, loads the
// output register, which drives m_axis_tvalid_o. The input side stalls only when a
// finished result is still waiting in the output register and the word in the input
// register is a final character. The zone offset (reset 8) is written through
// cfg_we_i; the user must write it only while no sentence is in flight, which the
// block itself does not enforce.
module nmea_rmc_time_extract_top #(
  parameter int unsigned MAX_LEN = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,     // zone_offset_hours
  // character stream in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] char_in
  input  wire logic        s_axis_tlast_i,  // last_char
  // result out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [nrte_pkg::OutDataW-1:0] m_axis_tdata_o,  // [4:0] hour, [11:5] minute,
                                                         // [18:12] second
  output logic [0:0]       m_axis_tuser_o   // [0] accepted
);

  logic [nrte_pkg::OfsW-1:0]  zone_q;

  // input register
  logic                       in_valid_q;
  logic [nrte_pkg::CharW-1:0] in_char_q;
  logic                       in_last_q;

  // output register
  logic                       out_valid_q;
  logic                       out_ok_q;
  logic [nrte_pkg::HourW-1:0] out_hour_q;
  logic [nrte_pkg::MinW-1:0]  out_min_q;
  logic [nrte_pkg::SecW-1:0]  out_sec_q;

  // held time
  logic [nrte_pkg::HourW-1:0] hold_hour_q, hold_hour_d;
  logic [nrte_pkg::MinW-1:0]  hold_min_q, hold_min_d;
  logic [nrte_pkg::SecW-1:0]  hold_sec_q, hold_sec_d;

  logic                       out_free;
  logic                       advance;
  logic                       s_accept;
  logic                       emit;
  nrte_pkg::verdict_t         verdict;
  logic [7:0]                 hour_raw;
  logic [7:0]                 hour_sum;
  logic [7:0]                 hour_wrap;
  logic [7:0]                 min_val;
  logic [7:0]                 sec_val;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  // a final character needs a free output slot; others move on freely
  assign advance         = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign emit            = advance && in_last_q;

  nrte_sentence #(
    .MAX_LEN (MAX_LEN)
  ) u_sentence (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .verdict_o (verdict)
  );

  // local time from the digit field
  always_comb begin
    hour_raw  = nrte_pkg::two_digits(verdict.digits[0], verdict.digits[1]);
    hour_sum  = hour_raw + {3'd0, zone_q};
    hour_wrap = (hour_sum >= nrte_pkg::HoursPerDay) ? hour_sum - nrte_pkg::HoursPerDay
                                                    : hour_sum;
    min_val   = nrte_pkg::two_digits(verdict.digits[2], verdict.digits[3]);
    sec_val   = nrte_pkg::two_digits(verdict.digits[4], verdict.digits[5]);

    hold_hour_d = hold_hour_q;
    hold_min_d  = hold_min_q;
    hold_sec_d  = hold_sec_q;
    if (verdict.ok) begin
      hold_hour_d = hour_wrap[nrte_pkg::HourW-1:0];
      hold_min_d  = min_val[nrte_pkg::MinW-1:0];
      hold_sec_d  = sec_val[nrte_pkg::SecW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= nrte_pkg::OfsW'(8);
    end else if (cfg_we_i) begin
      zone_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_hour_q <= '0;
      hold_min_q  <= '0;
      hold_sec_q  <= '0;
    end else if (emit) begin
      hold_hour_q <= hold_hour_d;
      hold_min_q  <= hold_min_d;
      hold_sec_q  <= hold_sec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ok_q   <= verdict.ok;
      out_hour_q <= hold_hour_d;
      out_min_q  <= hold_min_d;
      out_sec_q  <= hold_sec_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_sec_q, out_min_q, out_hour_q};
  assign m_axis_tuser_o  = out_ok_q;

  // a result appears only right after a final character went through
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("result word without a final character");

  // input side never stalls while the output slot can take a result
  a_no_needless_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free |-> s_axis_tready_o)
    else $error("input stalled with a free output slot");

  // a pending final character is held while the output is blocked
  a_last_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && !out_free) |=> (in_valid_q && in_last_q))
    else $error("final character lost while output blocked");

endmodule

`default_nettype wire
